>>> rtl/rate_monotonic_tick_scheduler_assert.svh
// assertion macros for the rate monotonic tick scheduler
// used by the rtl file that carries concurrent assertions; no other dependencies
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle as the antecedent
`define RMTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmts assertion failed");
// consequent must hold in the cycle after the antecedent
`define RMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmts assertion failed");
`else
`define RMTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/rmts_pkg.sv
// shared types and constants for the rate monotonic tick scheduler
// no dependencies; used by the scheduler and rmts_mod rtl files, not by rmts_ram
package rmts_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = 5;
  localparam int DATA_W      = 16;
  localparam int TIME_W      = 32;

  // input word modes
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  task_index;
    logic [DATA_W-1:0] compute_time;
    logic [DATA_W-1:0] period;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic              running;
    logic [CNT_W-1:0]  task_number;
  } out_word_t;

  // task table entry, written by loads only
  typedef struct packed {
    logic [DATA_W-1:0] compute;
    logic [DATA_W-1:0] period;
  } tbl_entry_t;

  // per-task run state: remaining work and phase of the upcoming tick
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] phase;
  } st_entry_t;

  // status of the modulo unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MOD,
    ST_UPD,
    ST_FIN
  } sched_state_t;

endpackage

>>> rtl/rate_monotonic_tick_scheduler.sv
// load and restart words are done in the idle state; a tick scans the n active tasks
// by a sequential read-modify-write of the task state ram, one entry at a time.
// an entry whose phase is unknown (after a load or a task_count write) also passes
// through the bit-serial remainder unit. results sit in an output register, 1 word deep.
// synchronous active-low reset: task_count 1, time 0, all remaining work 0; no clear pass.
`include "rate_monotonic_tick_scheduler_assert.svh"
module rate_monotonic_tick_scheduler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rmts_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rmts_pkg::out_word_t        out_data,
  input  logic                       cfg_we,
  input  logic [rmts_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int N  = rmts_pkg::NUM_ENTRIES;
  localparam int IW = rmts_pkg::IDX_W;
  localparam int CW = rmts_pkg::CNT_W;
  localparam int DW = rmts_pkg::DATA_W;
  localparam int TW = rmts_pkg::TIME_W;

  rmts_pkg::sched_state_t state_r, state_nxt;
  logic [CW-1:0]       tc_r, tc_nxt;
  logic [TW-1:0]       time_r, time_nxt;
  logic [N-1:0]        st_vld_r, st_vld_nxt;
  logic [N-1:0]        ph_vld_r, ph_vld_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                use_mod_r, use_mod_nxt;
  logic [IW-1:0]       best_r, best_nxt;
  logic [DW-1:0]       best_p_r, best_p_nxt;
  logic [DW-1:0]       best_rem_r, best_rem_nxt;
  logic [DW-1:0]       best_ph_r, best_ph_nxt;
  rmts_pkg::out_word_t out_data_r, out_data_nxt;

  logic                 tbl_we;
  rmts_pkg::tbl_entry_t tbl_wdata, tbl_rd;
  logic                 st_we;
  logic [IW-1:0]        st_waddr;
  rmts_pkg::st_entry_t  st_wdata, st_rd;
  logic                 mod_start;
  rmts_pkg::mod_stat_t  mod_stat;
  logic [DW-1:0]        mod_rem;

  logic [CW-1:0] n_act;
  logic          last_entry;
  logic [DW-1:0] rem_cur, phase_cur, rem_new, phase_next;
  logic [DW:0]   phase_inc;
  logic          releases, fin_go;

  // task table and run state memories, both read at the scan index
  rmts_ram #(.WIDTH(2 * DW), .DEPTH(N)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_data.task_index),
    .wdata (tbl_wdata),
    .raddr (idx_r),
    .rdata (tbl_rd)
  );

  rmts_ram #(.WIDTH(2 * DW), .DEPTH(N)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (idx_r),
    .rdata (st_rd)
  );

  // phase recovery when the stored phase is unknown
  rmts_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (time_r),
    .divisor  (tbl_rd.period),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  assign tbl_wdata.compute = in_data.compute_time;
  assign tbl_wdata.period  = in_data.period;

  // active entry count, saturated at the table depth
  assign n_act      = (tc_r > CW'(N)) ? CW'(N) : tc_r;
  assign last_entry = (CW'(idx_r) + CW'(1)) == n_act;

  // per-entry release and phase advance
  assign rem_cur    = st_vld_r[idx_r] ? st_rd.rem : '0;
  assign phase_cur  = use_mod_r ? mod_rem : (st_vld_r[idx_r] ? st_rd.phase : '0);
  assign releases   = (tbl_rd.period != '0) && (phase_cur == '0);
  assign rem_new    = releases ? tbl_rd.compute : rem_cur;
  assign phase_inc  = {1'b0, phase_cur} + (DW + 1)'(1);
  assign phase_next = ((time_r == '1) || (phase_inc == {1'b0, tbl_rd.period}))
                      ? '0 : phase_inc[DW-1:0];

  assign fin_go = (state_r == rmts_pkg::ST_FIN) && (!out_valid_r || out_ready);

  // sequencer: next state and datapath controls
  always_comb begin
    state_nxt     = state_r;
    tc_nxt        = tc_r;
    time_nxt      = time_r;
    st_vld_nxt    = st_vld_r;
    ph_vld_nxt    = ph_vld_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    use_mod_nxt   = use_mod_r;
    best_nxt      = best_r;
    best_p_nxt    = best_p_r;
    best_rem_nxt  = best_rem_r;
    best_ph_nxt   = best_ph_r;
    out_data_nxt  = out_data_r;
    tbl_we        = 1'b0;
    st_we         = 1'b0;
    st_waddr      = idx_r;
    st_wdata.rem  = rem_new;
    st_wdata.phase = phase_next;
    mod_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rmts_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.mode)
            rmts_pkg::MODE_LOAD: begin
              tbl_we                         = 1'b1;
              st_vld_nxt[in_data.task_index] = 1'b0;
              ph_vld_nxt[in_data.task_index] = 1'b0;
            end
            rmts_pkg::MODE_TICK: begin
              found_nxt = 1'b0;
              idx_nxt   = '0;
              state_nxt = (n_act == '0) ? rmts_pkg::ST_FIN : rmts_pkg::ST_READ;
            end
            rmts_pkg::MODE_RESTART: begin
              st_vld_nxt = '0;
              ph_vld_nxt = '1;
              time_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      rmts_pkg::ST_READ: begin
        state_nxt = rmts_pkg::ST_EVAL;
      end
      rmts_pkg::ST_EVAL: begin
        if ((tbl_rd.period != '0) && !ph_vld_r[idx_r]) begin
          mod_start   = 1'b1;
          use_mod_nxt = 1'b1;
          state_nxt   = rmts_pkg::ST_MOD;
        end else begin
          use_mod_nxt = 1'b0;
          state_nxt   = rmts_pkg::ST_UPD;
        end
      end
      rmts_pkg::ST_MOD: begin
        if (mod_stat.done) begin
          state_nxt = rmts_pkg::ST_UPD;
        end
      end
      rmts_pkg::ST_UPD: begin
        st_we             = 1'b1;
        st_vld_nxt[idx_r] = 1'b1;
        if (tbl_rd.period != '0) begin
          ph_vld_nxt[idx_r] = 1'b1;
        end
        // shortest period wins, ties to the lower entry
        if ((rem_new != '0) && (!found_r || (tbl_rd.period < best_p_r))) begin
          found_nxt    = 1'b1;
          best_nxt     = idx_r;
          best_p_nxt   = tbl_rd.period;
          best_rem_nxt = rem_new;
          best_ph_nxt  = phase_next;
        end
        if (last_entry) begin
          state_nxt = rmts_pkg::ST_FIN;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = rmts_pkg::ST_READ;
        end
      end
      rmts_pkg::ST_FIN: begin
        if (fin_go) begin
          st_waddr       = best_r;
          st_wdata.rem   = best_rem_r - DW'(1);
          st_wdata.phase = best_ph_r;
          st_we          = found_r;
          out_valid_nxt  = 1'b1;
          out_data_nxt.tick_time   = time_r;
          out_data_nxt.running     = found_r;
          out_data_nxt.task_number = found_r ? (CW'(best_r) + CW'(1)) : '0;
          time_nxt       = time_r + TW'(1);
          found_nxt      = 1'b0;
          state_nxt      = rmts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmts_pkg::ST_IDLE;
      end
    endcase

    // task count write: every stored phase becomes unknown
    if (cfg_we) begin
      tc_nxt     = cfg_wdata;
      ph_vld_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmts_pkg::ST_IDLE;
      tc_r        <= CW'(1);
      time_r      <= '0;
      st_vld_r    <= '0;
      ph_vld_r    <= '1;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tc_r        <= tc_nxt;
      time_r      <= time_nxt;
      st_vld_r    <= st_vld_nxt;
      ph_vld_r    <= ph_vld_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    use_mod_r  <= use_mod_nxt;
    best_r     <= best_nxt;
    best_p_r   <= best_p_nxt;
    best_rem_r <= best_rem_nxt;
    best_ph_r  <= best_ph_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == rmts_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `RMTS_ASSERT_NEXT(a_fin_loads_out, clk, rst_n, fin_go, out_valid_r)
  `RMTS_ASSERT_SAME(a_dec_nonzero, clk, rst_n, fin_go && found_r, best_rem_r != '0)
  `RMTS_ASSERT_SAME(a_scan_in_range, clk, rst_n, state_r == rmts_pkg::ST_UPD, CW'(idx_r) < n_act)
  `RMTS_ASSERT_SAME(a_mod_wait, clk, rst_n, state_r == rmts_pkg::ST_MOD, mod_stat.busy || mod_stat.done)

endmodule

>>> rtl/rmts_ram.sv
// generic single write port, single read port ram with registered read data
// no package dependencies
module rmts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rmts_mod.sv
// iterative remainder unit: 32-bit time modulo 16-bit period, one bit per cycle
// depends on rmts_pkg
module rmts_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rmts_pkg::TIME_W-1:0] dividend,
  input  logic [rmts_pkg::DATA_W-1:0] divisor,
  output rmts_pkg::mod_stat_t       stat,
  output logic [rmts_pkg::DATA_W-1:0] rem
);

  localparam int STEP_W = $clog2(rmts_pkg::TIME_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           cnt_r, cnt_nxt;
  logic [rmts_pkg::TIME_W-1:0] dvd_r, dvd_nxt;
  logic [rmts_pkg::DATA_W-1:0] dvs_r, dvs_nxt;
  logic [rmts_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [rmts_pkg::DATA_W:0]   shifted;
  logic [rmts_pkg::DATA_W:0]   diff;

  // one restoring step
  assign shifted = {rem_r, dvd_r[rmts_pkg::TIME_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = diff[rmts_pkg::DATA_W] ? shifted[rmts_pkg::DATA_W-1:0]
                                       : diff[rmts_pkg::DATA_W-1:0];
      dvd_nxt = {dvd_r[rmts_pkg::TIME_W-2:0], 1'b0};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(rmts_pkg::TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

>>> tb/rate_monotonic_tick_scheduler_tb.sv
// self-checking testbench for the rate monotonic tick scheduler
// needs rmts_pkg and the rate_monotonic_tick_scheduler rtl; reads no files
// a scoreboard class predicts each tick result and checks the output stream
module rate_monotonic_tick_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NE = rmts_pkg::NUM_ENTRIES;
  localparam int IW = rmts_pkg::IDX_W;
  localparam int CW = rmts_pkg::CNT_W;
  localparam int DW = rmts_pkg::DATA_W;
  localparam int TW = rmts_pkg::TIME_W;

  // mode value that the block ignores
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // worst tick: 16-entry scan plus a remainder pass for every entry
  localparam int DRAIN_CYCLES    = 600;
  localparam int QUIET_LIMIT     = 20000;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 208;

  // predicts the schedule and holds the tick results still owed by the block
  class tick_scoreboard;
    logic [CW-1:0]       task_count;
    logic [DW-1:0]       compute_tbl [NE];
    logic [DW-1:0]       period_tbl  [NE];
    logic [DW-1:0]       work_left   [NE];
    logic [TW-1:0]       now;
    rmts_pkg::out_word_t owed_ticks [$];
    int                  errors;
    int                  words_in;
    int                  ticks_checked;

    function new();
      task_count = CW'(1);
      now = '0;
      errors = 0;
      words_in = 0;
      ticks_checked = 0;
      foreach (work_left[i]) begin
        compute_tbl[i] = '0;
        period_tbl[i]  = '0;
        work_left[i]   = '0;
      end
    endfunction

    function void set_task_count(logic [CW-1:0] value);
      task_count = value;
    endfunction

    function int pending();
      return owed_ticks.size();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%t ERROR: %s", $realtime, msg);
    endfunction

    // one accepted input word
    function void note_word(rmts_pkg::in_word_t w);
      int active;
      int best;
      bit found;
      logic [DW-1:0] best_period;
      rmts_pkg::out_word_t owed;
      words_in++;
      case (w.mode)
        rmts_pkg::MODE_LOAD: begin
          compute_tbl[w.task_index] = w.compute_time;
          period_tbl[w.task_index]  = w.period;
          work_left[w.task_index]   = '0;
        end
        rmts_pkg::MODE_RESTART: begin
          foreach (work_left[i]) work_left[i] = '0;
          now = '0;
        end
        rmts_pkg::MODE_TICK: begin
          active = (task_count > NE) ? NE : int'(task_count);
          // release every entry whose period divides the time
          for (int i = 0; i < active; i++) begin
            if (period_tbl[i] != '0 && (now % period_tbl[i]) == '0)
              work_left[i] = compute_tbl[i];
          end
          // shortest period wins, lower entry on a tie
          found = 1'b0;
          best = 0;
          best_period = '0;
          for (int i = 0; i < active; i++) begin
            if (work_left[i] != '0 && (!found || period_tbl[i] < best_period)) begin
              found = 1'b1;
              best = i;
              best_period = period_tbl[i];
            end
          end
          owed.tick_time = now;
          owed.running = found;
          owed.task_number = '0;
          if (found) begin
            work_left[best] = work_left[best] - 1'b1;
            owed.task_number = CW'(best + 1);
          end
          owed_ticks.push_back(owed);
          now = now + 1'b1;
        end
        default: ;
      endcase
    endfunction

    // one accepted result word
    function void check_result(rmts_pkg::out_word_t got);
      rmts_pkg::out_word_t owed;
      if (owed_ticks.size() == 0) begin
        note_error($sformatf("result with nothing owed: time %0d run %0b task %0d",
                             got.tick_time, got.running, got.task_number));
        return;
      end
      owed = owed_ticks.pop_front();
      ticks_checked++;
      if (got.tick_time !== owed.tick_time || got.running !== owed.running ||
          got.task_number !== owed.task_number)
        note_error($sformatf({"tick mismatch: exp time %0d run %0b task %0d,",
                              " got time %0d run %0b task %0d"},
                             owed.tick_time, owed.running, owed.task_number,
                             got.tick_time, got.running, got.task_number));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rmts_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rmts_pkg::out_word_t out_data;
  logic                cfg_we = 1'b0;
  logic [CW-1:0]       cfg_wdata = '0;

  tick_scoreboard sb;
  int sender_idle_pct = 30;
  int receiver_idle_pct = 86;
  int quiet_cycles = 0;
  int settings_used = 0;

  rate_monotonic_tick_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // handshake monitor, results first since a result never answers a word accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_word(in_data);
    end
  end

  // watchdog on cycles without any handshake or task count write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d ticks owed",
               QUIET_LIMIT, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // present one word and hold it until accepted
  task automatic send_word(input logic [1:0] mode, input logic [IW-1:0] idx,
                           input logic [DW-1:0] compute, input logic [DW-1:0] period);
    rmts_pkg::in_word_t w;
    w.mode = mode;
    w.task_index = idx;
    w.compute_time = compute;
    w.period = period;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drain the block, then write the task count
  task automatic apply_task_count(input logic [CW-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_task_count(value);
    settings_used++;
  endtask

  // random words: mostly ticks, loads mostly with small periods so releases happen often
  task automatic run_random_phase(input logic [CW-1:0] count);
    int sent;
    int sel;
    logic [1:0] mode;
    logic [IW-1:0] idx;
    logic [DW-1:0] compute;
    logic [DW-1:0] period;
    apply_task_count(count);
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      sel = $urandom_range(99);
      idx = IW'($urandom_range(NE - 1));
      compute = DW'($urandom_range(16'hFFFF));
      period = DW'($urandom_range(16'hFFFF));
      if (sel < 3) begin
        mode = MODE_UNUSED;
      end else if (sel < 6) begin
        mode = rmts_pkg::MODE_RESTART;
      end else if (sel < 24) begin
        mode = rmts_pkg::MODE_LOAD;
        if ($urandom_range(4) != 0) begin
          compute = DW'($urandom_range(4));
          period = DW'($urandom_range(12));
        end
      end else begin
        mode = rmts_pkg::MODE_TICK;
      end
      send_word(mode, idx, compute, period);
      if (mode != MODE_UNUSED) sent++;
    end
  endtask

  logic [CW-1:0] phase_counts [RANDOM_PHASES] =
    '{5'd16, 5'd0, 5'd5, 5'd31, 5'd1, 5'd17, 5'd9, 5'd16, 5'd3};

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill every entry so no tick reads an unwritten one
    send_word(rmts_pkg::MODE_LOAD, 4'd0, 16'd2, 16'd4);
    send_word(rmts_pkg::MODE_LOAD, 4'd1, 16'd1, 16'd3);
    send_word(rmts_pkg::MODE_LOAD, 4'd2, 16'hFFFF, 16'hFFFF);  // field maximum
    send_word(rmts_pkg::MODE_LOAD, 4'd3, 16'd5, 16'd0);        // zero period, never released
    send_word(rmts_pkg::MODE_LOAD, 4'd4, 16'd0, 16'd1);        // released each tick, no work
    send_word(rmts_pkg::MODE_LOAD, 4'd5, 16'd1, 16'd2);        // equal periods, lower wins
    send_word(rmts_pkg::MODE_LOAD, 4'd6, 16'd1, 16'd2);
    for (int i = 7; i < NE; i++)
      send_word(rmts_pkg::MODE_LOAD, IW'(i), 16'd1, DW'(i + 8));
    send_word(MODE_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);  // ignored mode
    send_word(rmts_pkg::MODE_TICK, 4'd0, 16'd0, 16'd0);
    send_word(rmts_pkg::MODE_TICK, 4'd0, 16'd0, 16'd0);
    apply_task_count(5'd16);
    repeat (4) send_word(rmts_pkg::MODE_TICK, 4'd0, 16'd0, 16'd0);
    send_word(rmts_pkg::MODE_RESTART, 4'd0, 16'd0, 16'd0);
    send_word(rmts_pkg::MODE_TICK, 4'd0, 16'd0, 16'd0);

    // random: idling on both sides, then swapped, then none
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph / 3)
        0: begin
          sender_idle_pct = 30;
          receiver_idle_pct = 86;
        end
        1: begin
          sender_idle_pct = 86;
          receiver_idle_pct = 30;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      run_random_phase(phase_counts[ph]);
    end

    // wind down
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.note_error($sformatf("%0d ticks never arrived", sb.pending()));

    $display("covered %0d accepted words and %0d checked ticks over %0d task count settings",
             sb.words_in, sb.ticks_checked, settings_used);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rmts_pkg.sv
rtl/rmts_ram.sv
rtl/rmts_mod.sv
rtl/rate_monotonic_tick_scheduler.sv
tb/rate_monotonic_tick_scheduler_tb.sv
